// ===== hw/rtl/fts_pkg.sv =====
package fts_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned LenW    = 24;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CfgIdxW = 2;

  // one quotient bit per divider step, every quotient here is below 256
  localparam int unsigned DivSteps = 8;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  localparam logic [CfgIdxW-1:0] CfgPauseLen   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgFadeOutLen = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgFadeInLen  = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgAnimCount  = 2'd3;

  typedef struct packed {
    logic [LenW-1:0]  pause_length;
    logic [LenW-1:0]  fade_out_length;
    logic [LenW-1:0]  fade_in_length;
    logic [ByteW-1:0] animation_count;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== hw/rtl/fade_transition_sequencer_top.sv =====
// Fade transition sequencer. Each accepted time_now tick yields exactly one result with the
// fade-to-black amount, the selected animation and an advanced flag. A tick in the pause goes
// from StPhase straight to StOut and a tick at the end of a cycle passes StSetup as well; a fade
// tick adds one run of the shared 8-step restoring divider in StFade, and the tick that
// advances the animation adds a second run for the animation modulo in StModW.
// The divider is the only arithmetic unit that iterates. in_ready_o is
// high only while no tick is in work; a finished result may wait in the output register while
// the next tick is accepted. Configuration writes are always taken and should be made between
// ticks; the register index selects pause, fade-out, fade-in length or animation count.
module fade_transition_sequencer_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [fts_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [fts_pkg::LenW-1:0]      cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [fts_pkg::TimeW-1:0]     time_now_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [fts_pkg::ByteW-1:0]     fade_amount_o,
  output logic [fts_pkg::ByteW-1:0]     animation_number_o,
  output logic                          advanced_o
);
  import fts_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StSince = 3'd1;
  localparam logic [2:0] StPhase = 3'd2;
  localparam logic [2:0] StSetup = 3'd3;
  localparam logic [2:0] StFade  = 3'd4;
  localparam logic [2:0] StModW  = 3'd5;
  localparam logic [2:0] StOut   = 3'd6;

  cfg_t      cfg;
  div_stat_t div_stat;

  logic [2:0]       state_q, state_d;
  logic [TimeW-1:0] now_q, now_d;
  logic [TimeW-1:0] since_q, since_d;
  logic [TimeW-1:0] t_q, t_d;
  logic [LenW:0]    both_q, both_d;
  logic             fade_in_q, fade_in_d;
  logic [TimeW-1:0] start_q, start_d;
  logic             switched_q, switched_d;
  logic [ByteW-1:0] fade_q, fade_d;
  logic [ByteW-1:0] anim_q, anim_d;
  logic             adv_q, adv_d;

  logic             out_valid_q, out_valid_d;
  logic [ByteW-1:0] out_fade_q, out_fade_d;
  logic [ByteW-1:0] out_anim_q, out_anim_d;
  logic             out_adv_q, out_adv_d;

  logic             div_start;
  logic [TimeW-1:0] div_dividend;
  logic [LenW-1:0]  div_divisor;
  logic [ByteW-1:0] div_quot;
  logic [LenW-1:0]  div_rem;
  logic [LenW:0]    left_wide;
  logic [LenW-1:0]  left;
  logic             in_req;

  fts_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  fts_divider u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .stat_o      (div_stat),
    .quotient_o  (div_quot),
    .remainder_o (div_rem)
  );

  assign in_ready_o = (state_q == StIdle);
  assign in_req     = in_valid_i && in_ready_o;

  // time still left in the fade-in, never above the fade-in length
  assign left_wide = both_q - t_q[LenW:0];
  assign left      = left_wide[LenW-1:0];

  always_comb begin
    state_d      = state_q;
    now_d        = now_q;
    since_d      = since_q;
    t_d          = t_q;
    both_d       = both_q;
    fade_in_d    = fade_in_q;
    start_d      = start_q;
    switched_d   = switched_q;
    fade_d       = fade_q;
    anim_d       = anim_q;
    adv_d        = adv_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_fade_d   = out_fade_q;
    out_anim_d   = out_anim_q;
    out_adv_d    = out_adv_q;
    div_start    = 1'b0;
    div_dividend = {t_q[LenW-1:0], {ByteW{1'b0}}};
    div_divisor  = cfg.fade_out_length;

    unique case (state_q)
      StIdle: begin
        if (in_req) begin
          now_d   = time_now_i;
          state_d = StSince;
        end
      end
      StSince: begin
        since_d = now_q - start_q;
        adv_d   = 1'b0;
        state_d = StPhase;
      end
      StPhase: begin
        if (since_q < {{(TimeW-LenW){1'b0}}, cfg.pause_length}) begin
          state_d = StOut;
        end else begin
          t_d     = since_q - {{(TimeW-LenW){1'b0}}, cfg.pause_length};
          both_d  = {1'b0, cfg.fade_out_length} + {1'b0, cfg.fade_in_length};
          state_d = StSetup;
        end
      end
      StSetup: begin
        if (t_q < {{(TimeW-LenW){1'b0}}, cfg.fade_out_length}) begin
          div_start = 1'b1;
          fade_in_d = 1'b0;
          state_d   = StFade;
        end else if (t_q < {{(TimeW-LenW-1){1'b0}}, both_q}) begin
          // 255 * left as 256 * left - left
          div_start    = 1'b1;
          div_dividend = {left, {ByteW{1'b0}}} - {{ByteW{1'b0}}, left};
          div_divisor  = cfg.fade_in_length;
          fade_in_d    = 1'b1;
          state_d      = StFade;
        end else begin
          switched_d = 1'b0;
          fade_d     = '0;
          start_d    = now_q;
          state_d    = StOut;
        end
      end
      StFade: begin
        if (div_stat.done) begin
          fade_d  = div_quot;
          state_d = StOut;
          if (fade_in_q && !switched_q) begin
            switched_d = 1'b1;
            if (cfg.animation_count != '0) begin
              div_start    = 1'b1;
              div_dividend = {{(TimeW-ByteW){1'b0}}, anim_q};
              div_divisor  = {{(LenW-ByteW){1'b0}}, cfg.animation_count};
              state_d      = StModW;
            end
          end
        end
      end
      StModW: begin
        if (div_stat.done) begin
          anim_d  = div_rem[ByteW-1:0] + 1'b1;
          adv_d   = 1'b1;
          state_d = StOut;
        end
      end
      StOut: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_fade_d  = fade_q;
          out_anim_d  = anim_q;
          out_adv_d   = adv_q;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      start_q     <= '0;
      switched_q  <= 1'b0;
      fade_q      <= '0;
      anim_q      <= ByteW'(1);
      adv_q       <= 1'b0;
      fade_in_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      start_q     <= start_d;
      switched_q  <= switched_d;
      fade_q      <= fade_d;
      anim_q      <= anim_d;
      adv_q       <= adv_d;
      fade_in_q   <= fade_in_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q      <= now_d;
    since_q    <= since_d;
    t_q        <= t_d;
    both_q     <= both_d;
    out_fade_q <= out_fade_d;
    out_anim_q <= out_anim_d;
    out_adv_q  <= out_adv_d;
  end

  assign out_valid_o        = out_valid_q;
  assign fade_amount_o      = out_fade_q;
  assign animation_number_o = out_anim_q;
  assign advanced_o         = out_adv_q;

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == StFade || state_q == StModW))
    else $error("divider result with nobody waiting");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_req |=> state_q == StSince)
    else $error("accepted request not started");

  a_adv_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && advanced_o) |-> animation_number_o != '0)
    else $error("advanced to animation zero");

endmodule

// ===== hw/rtl/fts_cfg_regs.sv =====
module fts_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [fts_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [fts_pkg::LenW-1:0]      cfg_data_i,
  output fts_pkg::cfg_t                 cfg_o
);
  import fts_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgPauseLen:   cfg_d.pause_length    = cfg_data_i;
        CfgFadeOutLen: cfg_d.fade_out_length = cfg_data_i;
        CfgFadeInLen:  cfg_d.fade_in_length  = cfg_data_i;
        CfgAnimCount:  cfg_d.animation_count = cfg_data_i[ByteW-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== hw/rtl/fts_divider.sv =====
module fts_divider (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [fts_pkg::TimeW-1:0]  dividend_i,
  input  logic [fts_pkg::LenW-1:0]   divisor_i,
  output fts_pkg::div_stat_t         stat_o,
  output logic [fts_pkg::ByteW-1:0]  quotient_o,
  output logic [fts_pkg::LenW-1:0]   remainder_o
);
  import fts_pkg::*;

  logic [TimeW-1:0]   rem_q, rem_d;
  logic [TimeW-1:0]   dsh_q, dsh_d;
  logic [ByteW-1:0]   quot_q, quot_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic               ge;

  assign ge = (rem_q >= dsh_q);

  always_comb begin
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = dividend_i;
      // divisor aligned to the top quotient bit
      dsh_d  = {1'b0, divisor_i, {(DivSteps-1){1'b0}}};
      quot_d = '0;
      cnt_d  = DivCntW'(DivSteps - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (ge) begin
        rem_d = rem_q - dsh_q;
      end
      quot_d = {quot_q[ByteW-2:0], ge};
      dsh_d  = dsh_q >> 1;
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dsh_q  <= dsh_d;
    quot_q <= quot_d;
  end

  assign stat_o.busy  = busy_q;
  assign stat_o.done  = done_q;
  assign quotient_o   = quot_q;
  assign remainder_o  = rem_q[LenW-1:0];

endmodule

// ===== verif/fade_transition_sequencer_top_tb.sv =====
module fade_transition_sequencer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [23:0] LenMax = 24'hFFFFFF;
  localparam int unsigned HoldLen = 400;
  localparam int unsigned StallLimit = 3000;

  typedef struct packed {
    logic [7:0] fade;
    logic [7:0] anim;
    logic       adv;
  } fade_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [23:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] time_now_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  fade_amount_o;
  logic [7:0]  animation_number_o;
  logic        advanced_o;

  fade_transition_sequencer_top dut (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .time_now_i,
    .out_valid_o,
    .out_ready_i,
    .fade_amount_o,
    .animation_number_o,
    .advanced_o
  );

  // mirror of the block's registers and state
  logic [23:0] pause_len = '0;
  logic [23:0] out_len = '0;
  logic [23:0] in_len = '0;
  logic [7:0]  anim_cnt = '0;
  logic [31:0] cyc_start = '0;
  logic        switched = 1'b0;
  logic [7:0]  fade_lvl = '0;
  logic [7:0]  cur_anim = 8'd1;

  logic [31:0]  tick_queue[$];
  fade_result_t fade_due[$];
  int unsigned  items_pushed = 0;
  int unsigned  results_seen = 0;
  int unsigned  fails = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  tick_gap = 0;
  int unsigned  stall_left = 0;
  int unsigned  next_hold_at = 300;
  logic         tick_taken = 1'b0;
  logic         calm = 1'b0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic fade_result_t step_fade(logic [31:0] now);
    logic [31:0]  since;
    logic [31:0]  t;
    logic [25:0]  span;
    fade_result_t r;
    since = now - cyc_start;
    r.adv = 1'b0;
    if (since >= {8'd0, pause_len}) begin
      t = since - pause_len;
      span = out_len + in_len;
      if (t < out_len) begin
        fade_lvl = 8'((64'(t) << 8) / out_len);
      end else if (t < span) begin
        fade_lvl = 8'((64'(span - t) * 255) / in_len);
        if (!switched) begin
          if (anim_cnt != 0) begin
            cur_anim = 8'(cur_anim % anim_cnt + 1);
            r.adv = 1'b1;
          end
          switched = 1'b1;
        end
      end else begin
        switched = 1'b0;
        fade_lvl = '0;
        cyc_start = now;
      end
    end
    r.fade = fade_lvl;
    r.anim = cur_anim;
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll = $urandom_range(99);
    if (calm || roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [23:0] pick_len();
    int unsigned roll = $urandom_range(99);
    if (roll < 10) return '0;
    if (roll < 75) return 24'($urandom_range(1, 40));
    if (roll < 95) return 24'($urandom_range(41, 3000));
    return 24'($urandom_range(LenMax - 15, LenMax));
  endfunction

  function automatic logic [7:0] pick_count();
    int unsigned roll = $urandom_range(99);
    if (roll < 10) return 8'd0;
    if (roll < 20) return 8'd1;
    if (roll < 30) return 8'd255;
    return 8'($urandom_range(2, 12));
  endfunction

  // request driver
  always @(negedge clk_i) begin
    if (!in_valid_i || tick_taken) begin
      if (tick_gap > 0) begin
        tick_gap <= tick_gap - 1;
        in_valid_i <= 1'b0;
      end else if (tick_queue.size() > 0) begin
        in_valid_i <= 1'b1;
        time_now_i <= tick_queue.pop_front();
        tick_gap <= pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result receiver, with a long hold-off after 300 results and every 700 results after that
  always @(negedge clk_i) begin
    if (results_seen >= next_hold_at) begin
      next_hold_at <= next_hold_at + 700;
      stall_left <= HoldLen;
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      stall_left <= pick_gap();
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    fade_result_t want;
    logic         moved;
    tick_taken <= in_valid_i && in_ready_o;
    if (rst_ni) begin
      moved = 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        moved = 1'b1;
        case (cfg_index_i)
          fts_pkg::CfgPauseLen:   pause_len = cfg_data_i;
          fts_pkg::CfgFadeOutLen: out_len = cfg_data_i;
          fts_pkg::CfgFadeInLen:  in_len = cfg_data_i;
          fts_pkg::CfgAnimCount:  anim_cnt = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        moved = 1'b1;
        fade_due.push_back(step_fade(time_now_i));
      end
      if (out_valid_o && out_ready_i) begin
        moved = 1'b1;
        results_seen++;
        if (fade_due.size() == 0) begin
          $error("result with no tick pending: fade_amount %0d", fade_amount_o);
          fails++;
        end else begin
          want = fade_due.pop_front();
          if (fade_amount_o !== want.fade) begin
            $error("fade_amount: expected %0d, got %0d", want.fade, fade_amount_o);
            fails++;
          end
          if (animation_number_o !== want.anim) begin
            $error("animation_number: expected %0d, got %0d", want.anim, animation_number_o);
            fails++;
          end
          if (advanced_o !== want.adv) begin
            $error("advanced: expected %0d, got %0d", want.adv, advanced_o);
            fails++;
          end
        end
      end
      if (moved) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= StallLimit) begin
        $display("fade_transition_sequencer_top verification failed");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic write_all(input logic [23:0] p, input logic [23:0] o, input logic [23:0] i,
                           input logic [23:0] c);
    write_reg(fts_pkg::CfgPauseLen, p);
    write_reg(fts_pkg::CfgFadeOutLen, o);
    write_reg(fts_pkg::CfgFadeInLen, i);
    write_reg(fts_pkg::CfgAnimCount, c);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic queue_tick(input logic [31:0] t);
    tick_queue.push_back(t);
    items_pushed++;
  endtask

  // every tick answers, so after the last result only the pipeline needs to drain
  task automatic wait_idle();
    while (results_seen != items_pushed) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  initial begin
    logic [31:0] now_t;
    logic [31:0] base;
    logic [7:0]  cnt;
    int unsigned n;
    int unsigned roll;
    int unsigned cycle_len;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // all lengths zero: every tick ends a cycle
    queue_tick(32'h0000_0000);
    queue_tick(32'hFFFF_FFF0);
    wait_idle();

    // short phases starting near the top of the time range so the difference wraps
    write_all(24'd10, 24'd20, 24'd30, 24'd3);
    base = cyc_start;
    queue_tick(base + 5);
    queue_tick(base + 10);
    queue_tick(base + 29);
    queue_tick(base + 30);
    queue_tick(base + 31);
    queue_tick(base + 59);
    queue_tick(base + 60);
    queue_tick(base + 75);
    queue_tick(base + 100);
    wait_idle();

    // largest lengths, count field with upper data bits set
    write_all(LenMax, LenMax, LenMax, LenMax);
    base = cyc_start;
    queue_tick(base + LenMax - 1);
    queue_tick(base + LenMax);
    queue_tick(base + 2 * LenMax - 1);
    queue_tick(base + 2 * LenMax);
    queue_tick(base + 3 * LenMax - 1);
    queue_tick(base + 3 * LenMax);
    wait_idle();

    // zero pause and fade-out, zero count: fade-in without advancing
    write_all(24'd0, 24'd0, 24'd5, 24'd0);
    base = cyc_start;
    queue_tick(base);
    queue_tick(base + 4);
    queue_tick(base + 5);
    wait_idle();

    while (items_pushed < 1740) begin
      cnt = pick_count();
      write_all(pick_len(), pick_len(), pick_len(), {16'($urandom), cnt});
      calm = ($urandom_range(99) < 20);
      cycle_len = pause_len + out_len + in_len;
      now_t = cyc_start + $urandom_range(0, 3);
      n = $urandom_range(40, 150);
      repeat (n) begin
        roll = $urandom_range(99);
        if (roll < 8) begin
          queue_tick($urandom());
        end else begin
          if (roll < 12) begin
            now_t = now_t - $urandom_range(1, 50);
          end else begin
            now_t = now_t + $urandom_range(0, cycle_len / 10 + 2);
          end
          queue_tick(now_t);
        end
      end
      wait_idle();
    end
    calm = 1'b0;

    wait_idle();
    if (fails == 0) begin
      $display("fade_transition_sequencer_top verification clean");
    end else begin
      $display("fade_transition_sequencer_top verification failed");
    end
    $finish;
  end

endmodule
